>>> rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: terrace curve sampler shared types and constants
// Word layouts, state codes, divider request/response and saturation helper.
// ----------------------------------------------------------------------------
package tcs_pkg;

	// capacity and widths
	localparam int MAX_POINTS  = 16;
	localparam int PT_AW       = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int MAX_SAMPLES = 64;
	localparam int SC_W        = 7;
	localparam int D_W         = $clog2(MAX_SAMPLES);
	localparam int NUM_W       = 40;
	localparam int DIV_W       = 40;
	localparam int STEP_W      = 6;
	localparam int XDIV_STEPS  = DIV_W;
	localparam int ALPHA_STEPS = 31;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = SC_W;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_COUNT = 1'b0,
		REG_INVERT_CURVE = 1'b1
	} cfg_reg_t;

	// input word
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               last_point;
	} point_t;

	// output word
	typedef struct packed {
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic               last_sample;
	} sample_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RDF,
		ST_RDL,
		ST_INIT,
		ST_SCAN,
		ST_CMP,
		ST_SEG,
		ST_RD2,
		ST_RD3,
		ST_P,
		ST_XW,
		ST_AW,
		ST_Y,
		ST_YR,
		ST_EMIT
	} state_t;

	// divider request
	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem;
		logic [DIV_W-1:0]  dvd;
		logic [DIV_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	// divider response
	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	// clamp to signed 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/tcs_point_if.sv
// ----------------------------------------------------------------------------
// tcs_point_if: control point channel
// Valid/ready channel carrying one control point word.
// ----------------------------------------------------------------------------
interface tcs_point_if;
	logic            valid;
	logic            ready;
	tcs_pkg::point_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/tcs_sample_if.sv
// ----------------------------------------------------------------------------
// tcs_sample_if: curve sample channel
// Valid/ready channel carrying one sample word.
// ----------------------------------------------------------------------------
interface tcs_sample_if;
	logic             valid;
	logic             ready;
	tcs_pkg::sample_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram: simple dual port memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tcs_div.sv
// ----------------------------------------------------------------------------
// tcs_div: restoring divider
// One quotient bit a cycle; the remainder starts from a preset value.
// ----------------------------------------------------------------------------
module tcs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tcs_pkg::div_req_t  req,
	output tcs_pkg::div_rsp_t  rsp
);

	logic [tcs_pkg::DIV_W-1:0]  rem_q;
	logic [tcs_pkg::DIV_W-1:0]  dvd_q;
	logic [tcs_pkg::DIV_W-1:0]  den_q;
	logic [tcs_pkg::DIV_W-1:0]  quo_q;
	logic [tcs_pkg::STEP_W-1:0] cnt_q;
	logic                       busy_q;
	logic [tcs_pkg::DIV_W:0]    trial;
	logic                       ge;

	// shift in next dividend bit and compare
	assign trial = {rem_q, dvd_q[tcs_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == tcs_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			dvd_q <= req.dvd;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? tcs_pkg::DIV_W'(trial - {1'b0, den_q})
			            : trial[tcs_pkg::DIV_W-1:0];
			dvd_q <= {dvd_q[tcs_pkg::DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[tcs_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/terrace_curve_sampler_unit.sv
// ----------------------------------------------------------------------------
// terrace_curve_sampler_unit: terrace curve sampler
// Stores control points, then emits evenly spaced squared-alpha samples.
// ----------------------------------------------------------------------------
//  channel  | dir | word                                   | handshake
//  point    | in  | point_x, point_y (Q16.16), last_point  | valid/ready
//  sample   | out | sample_x, sample_y (int16), last_sample| valid/ready
//  cfg      | in  | cfg_index, cfg_data                    | cfg_we
//
// control points are accepted only while idle; the word with last_point starts
// sampling; for each sample the point scan reads the x memory once per point
// scanned, then the shared divider runs 40 steps for the position and 31
// steps for alpha; a single-point segment skips alpha; the first sample
// also passes through the RDF, RDL and INIT states
// no clearing pass after reset; point memories hold no reset value
// a waiting sample stalls the sequencer only at the output register
// ----------------------------------------------------------------------------
module terrace_curve_sampler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	tcs_point_if.sink                       point,
	tcs_sample_if.source                    sample,
	input  logic                            cfg_we,
	input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tcs_pkg::state_t state_q, state_d;

	logic [tcs_pkg::SC_W-1:0]   sc_q;
	logic                       inv_q;
	logic [tcs_pkg::CNT_W-1:0]  pc_q;
	logic [tcs_pkg::CNT_W-1:0]  cnt_q;
	logic [tcs_pkg::CNT_W-1:0]  pos_q;
	logic [tcs_pkg::D_W-1:0]    d_q;
	logic [tcs_pkg::D_W-1:0]    i_q;
	logic [tcs_pkg::PT_AW-1:0]  i2_q;
	logic                       eq_q;
	logic signed [31:0]         x1_q, xa_q, xb_q, ya_q, yb_q;
	logic signed [32:0]         dx_q;
	logic signed [tcs_pkg::NUM_W-1:0] num_q, p_q, q_q;
	logic signed [15:0]         sx_q, sy_q;
	logic [30:0]                asq_q;
	logic signed [64:0]         prod_q;
	logic                       out_valid_q;
	tcs_pkg::sample_t           out_q;

	logic                       in_acc, mem_we, out_load;
	logic [tcs_pkg::PT_AW-1:0]  raddr;
	logic [31:0]                rx, ry;
	logic [tcs_pkg::SC_W-1:0]   n_c;
	logic [tcs_pkg::PT_AW-1:0]  i1_c, i2_c;
	logic signed [32:0]         mul_a;
	logic signed [tcs_pkg::NUM_W-1:0] mul_p;
	tcs_pkg::div_req_t          div_req;
	tcs_pkg::div_rsp_t          div_rsp;
	logic signed [40:0]         xa_c, xsh_c, xdvd_c, xv_c;
	logic [31:0]                alpha_c;
	logic [63:0]                sq_c;
	logic signed [31:0]         ys_c, ye_c;
	logic signed [32:0]         dy_c;
	logic signed [65:0]         yq_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q  <= tcs_pkg::SC_W'(10);
			inv_q <= 1'b1;
		end else if (cfg_we) begin
			case (tcs_pkg::cfg_reg_t'(cfg_index))
				tcs_pkg::REG_SAMPLE_COUNT: sc_q  <= cfg_data;
				tcs_pkg::REG_INVERT_CURVE: inv_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// point memories, written only while idle so no read overlaps a write
	assign in_acc = point.valid && point.ready;
	assign mem_we = in_acc && (pc_q < tcs_pkg::CNT_W'(tcs_pkg::MAX_POINTS));

	tcs_ram #(.WIDTH(32), .DEPTH(tcs_pkg::MAX_POINTS)) u_ram_x (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pc_q[tcs_pkg::PT_AW-1:0]),
		.wdata (point.data.point_x),
		.raddr (raddr),
		.rdata (rx)
	);

	tcs_ram #(.WIDTH(32), .DEPTH(tcs_pkg::MAX_POINTS)) u_ram_y (
		.clk   (clk),
		.we    (mem_we),
		.waddr (pc_q[tcs_pkg::PT_AW-1:0]),
		.wdata (point.data.point_y),
		.raddr (raddr),
		.rdata (ry)
	);

	// clamped sample count
	always_comb begin
		if (sc_q < tcs_pkg::SC_W'(2)) begin
			n_c = tcs_pkg::SC_W'(2);
		end else if (sc_q > tcs_pkg::SC_W'(tcs_pkg::MAX_SAMPLES)) begin
			n_c = tcs_pkg::SC_W'(tcs_pkg::MAX_SAMPLES);
		end else begin
			n_c = sc_q;
		end
	end

	// segment ends from scan position
	assign i1_c = (pos_q == '0) ? '0 : tcs_pkg::PT_AW'(pos_q - 1'b1);
	assign i2_c = (pos_q >= cnt_q) ? tcs_pkg::PT_AW'(cnt_q - 1'b1)
	                               : pos_q[tcs_pkg::PT_AW-1:0];

	// shared multiply by the step divisor
	always_comb begin
		case (state_q)
			tcs_pkg::ST_INIT: mul_a = 33'(x1_q);
			tcs_pkg::ST_CMP:  mul_a = 33'($signed(rx));
			tcs_pkg::ST_RD3:  mul_a = 33'(xa_q);
			tcs_pkg::ST_P:    mul_a = 33'(xb_q) - 33'(xa_q);
			default: mul_a = '0;
		endcase
	end
	assign mul_p = mul_a * $signed({1'b0, d_q});

	// position dividend: floor((num + d/2*2^16) / 2^16) + d*2^31, always positive
	assign xa_c   = 41'(num_q) + 41'($signed({1'b0, d_q, 15'b0}));
	assign xsh_c  = xa_c >>> 16;
	assign xdvd_c = xsh_c + $signed({2'b0, d_q, 31'b0});
	assign xv_c   = $signed({1'b0, div_rsp.quo}) - 41'sd2147483648;

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			tcs_pkg::ST_SEG: begin
				div_req.start = 1'b1;
				div_req.dvd   = tcs_pkg::DIV_W'(xdvd_c);
				div_req.den   = tcs_pkg::DIV_W'(d_q);
				div_req.steps = tcs_pkg::STEP_W'(tcs_pkg::XDIV_STEPS);
			end
			tcs_pkg::ST_XW: begin
				div_req.start = !div_rsp.busy && !eq_q;
				div_req.rem   = p_q;
				div_req.den   = q_q;
				div_req.steps = tcs_pkg::STEP_W'(tcs_pkg::ALPHA_STEPS);
			end
			default: ;
		endcase
	end

	tcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// alpha, mirrored when inverted, then squared
	assign alpha_c = inv_q ? (32'h8000_0000 - {1'b0, div_rsp.quo[30:0]})
	                       : {1'b0, div_rsp.quo[30:0]};
	assign sq_c    = alpha_c * alpha_c + 64'h8000_0000;

	// interpolation
	assign ys_c = inv_q ? yb_q : ya_q;
	assign ye_c = inv_q ? ya_q : yb_q;
	assign dy_c = 33'(ye_c) - 33'(ys_c);
	assign yq_c = (66'(ys_c) <<< 30) + 66'(prod_q) + 66'sh2000_0000_0000;

	// output register
	assign out_load = (state_q == tcs_pkg::ST_EMIT) && (!out_valid_q || sample.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (sample.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sample_x    <= sx_q;
			out_q.sample_y    <= sy_q;
			out_q.last_sample <= (i_q == d_q);
		end
	end

	assign sample.valid = out_valid_q;
	assign sample.data  = out_q;
	assign point.ready  = (state_q == tcs_pkg::ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and read address
	always_comb begin
		state_d = state_q;
		raddr   = '0;
		case (state_q)
			tcs_pkg::ST_IDLE: begin
				if (in_acc && point.data.last_point) begin
					state_d = tcs_pkg::ST_RDF;
				end
			end
			tcs_pkg::ST_RDF: begin
				state_d = tcs_pkg::ST_RDL;
			end
			tcs_pkg::ST_RDL: begin
				raddr   = tcs_pkg::PT_AW'(cnt_q - 1'b1);
				state_d = tcs_pkg::ST_INIT;
			end
			tcs_pkg::ST_INIT: begin
				state_d = tcs_pkg::ST_SCAN;
			end
			tcs_pkg::ST_SCAN: begin
				raddr   = pos_q[tcs_pkg::PT_AW-1:0];
				state_d = (pos_q == cnt_q) ? tcs_pkg::ST_SEG : tcs_pkg::ST_CMP;
			end
			tcs_pkg::ST_CMP: begin
				state_d = (num_q < mul_p) ? tcs_pkg::ST_SEG : tcs_pkg::ST_SCAN;
			end
			tcs_pkg::ST_SEG: begin
				raddr   = i1_c;
				state_d = tcs_pkg::ST_RD2;
			end
			tcs_pkg::ST_RD2: begin
				raddr   = i2_q;
				state_d = tcs_pkg::ST_RD3;
			end
			tcs_pkg::ST_RD3: begin
				state_d = tcs_pkg::ST_P;
			end
			tcs_pkg::ST_P: begin
				state_d = tcs_pkg::ST_XW;
			end
			tcs_pkg::ST_XW: begin
				if (!div_rsp.busy) begin
					state_d = eq_q ? tcs_pkg::ST_Y : tcs_pkg::ST_AW;
				end
			end
			tcs_pkg::ST_AW: begin
				if (!div_rsp.busy) begin
					state_d = tcs_pkg::ST_Y;
				end
			end
			tcs_pkg::ST_Y: begin
				state_d = tcs_pkg::ST_YR;
			end
			tcs_pkg::ST_YR: begin
				state_d = tcs_pkg::ST_EMIT;
			end
			tcs_pkg::ST_EMIT: begin
				if (out_load) begin
					state_d = (i_q == d_q) ? tcs_pkg::ST_IDLE : tcs_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = tcs_pkg::ST_IDLE;
			end
		endcase
	end

	// point count, scan position and sample index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			d_q   <= '0;
			i_q   <= '0;
		end else begin
			if (in_acc) begin
				if (point.data.last_point) begin
					pc_q  <= '0;
					cnt_q <= mem_we ? pc_q + 1'b1 : pc_q;
					d_q   <= tcs_pkg::D_W'(n_c - 1'b1);
				end else if (mem_we) begin
					pc_q <= pc_q + 1'b1;
				end
			end
			case (state_q)
				tcs_pkg::ST_INIT: begin
					i_q   <= '0;
					pos_q <= '0;
				end
				tcs_pkg::ST_CMP: begin
					if (!(num_q < mul_p)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				tcs_pkg::ST_EMIT: begin
					if (out_load) begin
						// back to zero after the final sample of the curve
						i_q   <= (i_q == d_q) ? '0 : i_q + 1'b1;
						pos_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tcs_pkg::ST_RDL: begin
				x1_q <= rx;
			end
			tcs_pkg::ST_INIT: begin
				dx_q  <= 33'($signed(rx)) - 33'(x1_q);
				num_q <= mul_p;
			end
			tcs_pkg::ST_SEG: begin
				i2_q <= i2_c;
				eq_q <= (i1_c == i2_c);
			end
			tcs_pkg::ST_RD2: begin
				xa_q <= rx;
				ya_q <= ry;
			end
			tcs_pkg::ST_RD3: begin
				xb_q <= rx;
				yb_q <= ry;
				p_q  <= num_q - mul_p;
			end
			tcs_pkg::ST_P: begin
				q_q <= mul_p;
			end
			tcs_pkg::ST_XW: begin
				if (!div_rsp.busy) begin
					sx_q <= tcs_pkg::sat16(48'(xv_c));
					if (eq_q) begin
						asq_q <= '0;
					end
				end
			end
			tcs_pkg::ST_AW: begin
				if (!div_rsp.busy) begin
					asq_q <= sq_c[62:32];
				end
			end
			tcs_pkg::ST_Y: begin
				prod_q <= dy_c * $signed({1'b0, asq_q});
			end
			tcs_pkg::ST_YR: begin
				sy_q <= tcs_pkg::sat16(48'(yq_c >>> 46));
			end
			tcs_pkg::ST_EMIT: begin
				if (out_load) begin
					num_q <= num_q + tcs_pkg::NUM_W'(dx_q);
				end
			end
			default: ;
		endcase
	end

	// divider is never restarted mid-run
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// scan never passes the stored points
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tcs_pkg::ST_IDLE) |-> (pos_q <= cnt_q) && (cnt_q != '0))
		else $error("scan position out of range");

	// sample index stays within the curve
	a_sample_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tcs_pkg::ST_IDLE) |-> (i_q <= d_q))
		else $error("sample index beyond curve");

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: terrace curve sampler testbench
// Feeds control point curves over the point channel, predicts every sample
// word from a behavioural model of the curve fit or typed values, checks
// each one in order. A short directed table comes first, then random curves
// in phases with different sample counts, inversion and back-pressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  LIMIT_CYCLES = 20000000;
	localparam int  DRAIN_CYCLES = 200;
	localparam int  PHASE_ITEMS  = 80;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data;

	tcs_point_if  point ();
	tcs_sample_if sample ();

	terrace_curve_sampler_unit u_dut (
		.clk(clk), .arst_n(arst_n), .point(point), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model state
	logic signed [31:0] curve_x [tcs_pkg::MAX_POINTS];
	logic signed [31:0] curve_y [tcs_pkg::MAX_POINTS];
	int                 curve_len;
	logic [tcs_pkg::SC_W-1:0] samples_cfg;
	logic               invert_cfg;

	tcs_pkg::sample_t expected_samples [$];
	int      errors;
	int      snd_idle;
	int      rcv_idle;
	bit      hold_rx;
	int      phase;
	longint  cycles;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		bit                 last;
		bit                 typed;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
	} row_t;

	// directed rows; typed values only for single-point curves
	row_t dir_rows [] = '{
		'{32'sh0000_0000, 32'sh0000_0000, 1, 1, 16'sd0, 16'sd0},
		'{32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1, 16'sd32767, 16'sd32767},
		'{32'sh8000_0000, 32'sh8000_0000, 1, 1, -16'sd32768, -16'sd32768},
		'{32'sh0001_8000, 32'shffff_8000, 1, 1, 16'sd2, 16'sd0},
		'{32'sh0000_0000, 32'sh0000_0000, 0, 0, 0, 0},
		'{32'sh000a_0000, 32'sh0064_0000, 1, 0, 0, 0},
		'{32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0},
		'{32'sh7fff_ffff, 32'sh8000_0000, 1, 0, 0, 0},
		'{32'sh0005_0000, 32'sh0001_0000, 0, 0, 0, 0},
		'{32'sh0001_0000, 32'sh0010_0000, 0, 0, 0, 0},
		'{32'sh0009_0000, 32'shfff0_0000, 1, 0, 0, 0},
		'{32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 0},
		'{32'sh0002_0000, 32'sh0007_0000, 0, 0, 0, 0},
		'{32'sh0006_0000, 32'sh0001_0000, 1, 0, 0, 0}
	};

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// floor(p * 2^31 / q), restoring division
	function automatic longint unsigned alpha_q31(longint unsigned p, longint unsigned q);
		longint unsigned r, a;
		r = p;
		a = 0;
		for (int k = 0; k < 31; k++) begin
			r = r << 1;
			a = a << 1;
			if (r >= q) begin
				r = r - q;
				a = a | 1;
			end
		end
		return a;
	endfunction

	function automatic int curve_samples();
		int n;
		n = samples_cfg;
		if (n < 2)
			n = 2;
		if (n > tcs_pkg::MAX_SAMPLES)
			n = tcs_pkg::MAX_SAMPLES;
		return n;
	endfunction

	// store the point; on the last flag fit the curve and queue every sample
	task automatic predict_point(tcs_pkg::point_t p);
		longint n, d, x1, dx, num, yq, yr, ys, ye;
		longint unsigned pp, qq, al, asq;
		int cnt, pos, i1, i2;
		tcs_pkg::sample_t s;
		if (curve_len < tcs_pkg::MAX_POINTS) begin
			curve_x[curve_len] = p.point_x;
			curve_y[curve_len] = p.point_y;
			curve_len++;
		end
		if (!p.last_point)
			return;
		cnt = curve_len;
		curve_len = 0;
		n = curve_samples();
		d = n - 1;
		x1 = curve_x[0];
		dx = longint'(curve_x[cnt-1]) - x1;
		for (longint i = 0; i < n; i++) begin
			num = x1 * d + i * dx;
			pos = 0;
			while (pos < cnt && !(num < longint'(curve_x[pos]) * d))
				pos++;
			i1 = (pos == 0) ? 0 : pos - 1;
			i2 = (pos >= cnt) ? cnt - 1 : pos;
			if (i1 == i2) begin
				yr = floor_div(longint'(curve_y[i1]) + 32768, 65536);
			end else begin
				pp = num - longint'(curve_x[i1]) * d;
				qq = (longint'(curve_x[i2]) - longint'(curve_x[i1])) * d;
				al = alpha_q31(pp, qq);
				if (invert_cfg) begin
					al = (64'd1 << 31) - al;
					ys = curve_y[i2];
					ye = curve_y[i1];
				end else begin
					ys = curve_y[i1];
					ye = curve_y[i2];
				end
				asq = (al * al + (64'd1 << 31)) >> 32;
				yq = ys * (64'sd1 <<< 30) + (ye - ys) * longint'(asq);
				yr = floor_div(yq + (64'sd1 <<< 45), 64'sd1 <<< 46);
			end
			s.sample_x    = clamp16(floor_div(num + d * 32768, d * 65536));
			s.sample_y    = clamp16(yr);
			s.last_sample = (i == n - 1);
			expected_samples.push_back(s);
		end
	endtask

	task automatic report(string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	// offer one word and hold it until taken
	task automatic send_point(tcs_pkg::point_t p, bit typed, logic signed [15:0] ex,
			logic signed [15:0] ey);
		int n;
		tcs_pkg::sample_t s;
		while ($urandom_range(99) < snd_idle) begin
			point.valid <= 1'b0;
			@(posedge clk);
		end
		point.valid <= 1'b1;
		point.data  <= p;
		do @(posedge clk); while (!point.ready);
		if (typed && p.last_point) begin
			n = curve_samples();
			curve_len = 0;
			for (int i = 0; i < n; i++) begin
				s.sample_x = ex;
				s.sample_y = ey;
				s.last_sample = (i == n - 1);
				expected_samples.push_back(s);
			end
		end else begin
			predict_point(p);
		end
	endtask

	task automatic settle();
		point.valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(tcs_pkg::cfg_reg_t idx, logic [tcs_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == tcs_pkg::REG_SAMPLE_COUNT)
			samples_cfg = val;
		else
			invert_cfg = val[0];
	endtask

	// one random curve, occasionally past capacity or out of order
	task automatic send_curve(output int sent);
		int k, sel;
		int xs [$];
		int base;
		tcs_pkg::point_t p;
		sel = $urandom_range(99);
		if (sel < 8)
			k = 1;
		else if (sel < 20)
			k = $urandom_range(20, 14);
		else
			k = $urandom_range(8, 2);
		base = $urandom();
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(1))
				xs.push_back($urandom());
			else
				xs.push_back(base + int'($urandom_range(32'h00ff_ffff)));
		end
		if ($urandom_range(9) != 0)
			xs.sort();
		for (int i = 0; i < k; i++) begin
			p.point_x    = xs[i];
			p.point_y    = ($urandom_range(3) == 0) ? $urandom() :
				int'($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
			p.last_point = (i == k - 1);
			send_point(p, 0, 0, 0);
		end
		sent = k;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sample sink and checker
	initial begin
		tcs_pkg::sample_t got, want;
		sample.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sample.valid && sample.ready) begin
				got = sample.data;
				if (expected_samples.size() == 0) begin
					report($sformatf("unexpected word x=%0d y=%0d", got.sample_x,
						got.sample_y));
				end else begin
					want = expected_samples.pop_front();
					if (got.sample_x !== want.sample_x)
						report($sformatf("sample_x %0d want %0d", got.sample_x,
							want.sample_x));
					if (got.sample_y !== want.sample_y)
						report($sformatf("sample_y %0d want %0d", got.sample_y,
							want.sample_y));
					if (got.last_sample !== want.last_sample)
						report($sformatf("last_sample %0b want %0b", got.last_sample,
							want.last_sample));
				end
			end
			sample.ready <= !hold_rx && ($urandom_range(99) >= rcv_idle);
		end
	end

	// long receiver hold-off while points keep coming
	initial begin
		hold_rx = 0;
		wait (phase == 1);
		repeat (200) @(posedge clk);
		hold_rx = 1;
		repeat (3000) @(posedge clk);
		hold_rx = 0;
	end

	// stimulus
	initial begin
		int sent, cnt;
		logic [tcs_pkg::CFG_DATA_W-1:0] sc_tab [6] =
			'{7'd2, 7'd0, 7'd10, 7'd1, 7'd64, 7'd127};
		tcs_pkg::point_t p;
		errors = 0;
		cycles = 0;
		phase = 0;
		snd_idle = 6;
		rcv_idle = 75;
		curve_len = 0;
		samples_cfg = 10;
		invert_cfg = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point.valid = 1'b0;
		point.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table under reset settings
		foreach (dir_rows[r]) begin
			p.point_x = dir_rows[r].x;
			p.point_y = dir_rows[r].y;
			p.last_point = dir_rows[r].last;
			send_point(p, dir_rows[r].typed, dir_rows[r].ex, dir_rows[r].ey);
		end
		settle();

		// random phases, each with its own settings and idling
		for (int ph = 0; ph < 6; ph++) begin
			phase = ph;
			snd_idle = (ph < 2) ? 6 : (ph < 4) ? 75 : 0;
			rcv_idle = (ph < 2) ? 75 : (ph < 4) ? 6 : 0;
			write_reg(tcs_pkg::REG_SAMPLE_COUNT, sc_tab[ph]);
			write_reg(tcs_pkg::REG_INVERT_CURVE, tcs_pkg::CFG_DATA_W'(ph[0]));
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				send_curve(sent);
				cnt += sent;
			end
			settle();
		end

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
